>>> rtl/nbsp_pkg.sv
// Shared types and constants for the NaN bitmap sparse pack unit.
package nbsp_pkg;

  localparam int VALUE_W = 64;
  localparam int ROWLEN_W = 17;
  localparam int KEPT_W = 48;
  localparam int BITMAP_W = 64;
  localparam int GROUP_IDX_W = 6;
  localparam int RESULTS_MAX = 3;

  localparam logic [KEPT_W-1:0] KEPT_MAX = {KEPT_W{1'b1}};
  localparam logic [ROWLEN_W-1:0] ROWLEN_RESET = ROWLEN_W'(64);
  localparam logic [GROUP_IDX_W-1:0] GROUP_LAST_COL = {GROUP_IDX_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_BITMAP  = 2'd1,
    KIND_ROW_END = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] payload;
    logic               last;
  } result_t;

  // All results caused by one input beat, packed towards slot 0.
  typedef struct packed {
    logic [1:0]                count;
    result_t [RESULTS_MAX-1:0] res;
  } result_group_t;

endpackage

>>> rtl/nbsp_classify.sv
// Per-element NaN test, bitmap and count update, and result grouping.
module nbsp_classify #(
  parameter int MAX_COLUMNS = 65536,
  parameter int COL_W = 16
) (
  input  logic [nbsp_pkg::VALUE_W-1:0]  value_bits,
  input  logic                          panel_end,
  input  logic [nbsp_pkg::ROWLEN_W-1:0] row_length,
  input  logic [COL_W-1:0]              col,
  input  logic [nbsp_pkg::BITMAP_W-1:0] bitmap,
  input  logic [nbsp_pkg::KEPT_W-1:0]   kept,
  output logic [COL_W-1:0]              col_nxt,
  output logic [nbsp_pkg::BITMAP_W-1:0] bitmap_nxt,
  output logic [nbsp_pkg::KEPT_W-1:0]   kept_nxt,
  output nbsp_pkg::result_group_t       group
);
  import nbsp_pkg::*;

  localparam int CMP_W = (COL_W + 1 > ROWLEN_W) ? COL_W + 1 : ROWLEN_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_COLUMNS);

  logic                  is_nan;
  logic                  keep;
  logic [CMP_W-1:0]      len_raw;
  logic [CMP_W-1:0]      len_eff;
  logic                  row_end;
  logic                  word_end;
  logic [BITMAP_W-1:0]   bitmap_set;
  logic [KEPT_W-1:0]     kept_inc;
  logic [GROUP_IDX_W-1:0] group_col;

  assign is_nan = (&value_bits[62:52]) && (|value_bits[51:0]);
  assign keep = !is_nan;
  assign group_col = GROUP_IDX_W'(col);

  always_comb begin
    len_raw = CMP_W'(row_length);
    if (row_length == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_raw > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = len_raw;
    end
  end

  // A row also ends early if the length was shortened below the current column.
  assign row_end = panel_end || ((CMP_W'(col) + CMP_W'(1)) >= len_eff);
  assign word_end = row_end || (group_col == GROUP_LAST_COL);

  assign bitmap_set = bitmap | (keep ? (BITMAP_W'(1) << group_col) : '0);
  assign kept_inc = kept + KEPT_W'(keep && (kept != KEPT_MAX));

  assign bitmap_nxt = word_end ? '0 : bitmap_set;
  assign col_nxt = row_end ? '0 : col + COL_W'(1);
  assign kept_nxt = panel_end ? '0 : kept_inc;

  always_comb begin
    logic [1:0] n;
    n = '0;
    group = '0;
    if (keep) begin
      group.res[n] = '{kind: KIND_VALUE, payload: value_bits, last: 1'b0};
      n = n + 2'd1;
    end
    if (word_end) begin
      group.res[n] = '{kind: KIND_BITMAP, payload: bitmap_set, last: 1'b0};
      n = n + 2'd1;
    end
    if (row_end) begin
      group.res[n] = '{kind: KIND_ROW_END, payload: VALUE_W'(kept_inc), last: 1'b0};
      n = n + 2'd1;
    end
    if (n != '0) begin
      group.res[n - 2'd1].last = 1'b1;
    end
    group.count = n;
  end

endmodule

>>> rtl/nbsp_result_buf.sv
// Result buffer that holds one element's results and hands them out one beat at a time.
module nbsp_result_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  nbsp_pkg::result_group_t group,
  output logic                    can_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output nbsp_pkg::result_t       head
);
  import nbsp_pkg::*;

  logic [1:0]                cnt_r;
  result_t [RESULTS_MAX-1:0] res_r;
  logic                      pop;

  assign out_valid = (cnt_r != '0);
  assign pop = out_valid && out_ready;
  // A new group may be loaded as the final pending result leaves.
  assign can_load = (cnt_r == '0) || ((cnt_r == 2'd1) && out_ready);
  assign head = res_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= group.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= group.res;
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

endmodule

>>> rtl/nan_bitmap_sparse_pack_unit.sv
// Top level of the NaN bitmap sparse pack unit: input register, row state and result buffer.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_ready, in_value_bits, in_panel_end | sink
//   out     | out_valid, out_ready, out_kind, out_payload, out_last | source
//   cfg     | cfg_wr_en, cfg_wr_data                       | sink
//
// An element is registered on acceptance; its zero to three results are loaded into the
// result buffer once the buffer can take them. Elements with at most one result pass at
// one per cycle while out_ready is high; an element with several results uses the single
// output port one beat at a time. Synchronous reset clears the row state, the count and
// all pending beats, and sets the row length to 64. A stalled output holds the input.
module nan_bitmap_sparse_pack_unit #(
  parameter int MAX_COLUMNS = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nbsp_pkg::VALUE_W-1:0]  in_value_bits,
  input  logic                          in_panel_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [nbsp_pkg::VALUE_W-1:0]  out_payload,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [nbsp_pkg::ROWLEN_W-1:0] cfg_wr_data
);
  import nbsp_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic                in_valid_r;
  logic [VALUE_W-1:0]  in_value_r;
  logic                in_pend_r;
  logic [ROWLEN_W-1:0] row_length_r;
  logic [COL_W-1:0]    col_r;
  logic [BITMAP_W-1:0] bitmap_r;
  logic [KEPT_W-1:0]   kept_r;

  logic [COL_W-1:0]    col_nxt;
  logic [BITMAP_W-1:0] bitmap_nxt;
  logic [KEPT_W-1:0]   kept_nxt;
  result_group_t       group;
  result_t             head;
  logic                can_load;
  logic                advance;

  assign advance = in_valid_r && can_load;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      row_length_r <= ROWLEN_RESET;
      col_r        <= '0;
      bitmap_r     <= '0;
      kept_r       <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (cfg_wr_en) begin
        row_length_r <= cfg_wr_data;
      end
      if (advance) begin
        col_r    <= col_nxt;
        bitmap_r <= bitmap_nxt;
        kept_r   <= kept_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_value_r <= in_value_bits;
      in_pend_r  <= in_panel_end;
    end
  end

  nbsp_classify #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .COL_W      (COL_W)
  ) u_classify (
    .value_bits(in_value_r),
    .panel_end (in_pend_r),
    .row_length(row_length_r),
    .col       (col_r),
    .bitmap    (bitmap_r),
    .kept      (kept_r),
    .col_nxt   (col_nxt),
    .bitmap_nxt(bitmap_nxt),
    .kept_nxt  (kept_nxt),
    .group     (group)
  );

  nbsp_result_buf u_result_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .group    (group),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_kind = head.kind;
  assign out_payload = head.payload;
  assign out_last = head.last;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the NaN bitmap sparse pack unit, with its own row packing predictor.
module tb_top;
  import nbsp_pkg::*;

  localparam int MAX_COLUMNS = 65536;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [VALUE_W-1:0] bits;
    logic               pend;
  } elem_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [VALUE_W-1:0]  in_value_bits = '0;
  logic                in_panel_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_kind;
  logic [VALUE_W-1:0]  out_payload;
  logic                out_last;
  logic                cfg_wr_en = 1'b0;
  logic [ROWLEN_W-1:0] cfg_wr_data = '0;

  // Predictor state: a private copy of the row length and the row bookkeeping.
  logic [ROWLEN_W-1:0] row_len = ROWLEN_RESET;
  logic [BITMAP_W-1:0] valid_bits = '0;
  int unsigned         column = 0;
  logic [KEPT_W-1:0]   kept_count = '0;

  elem_t   pending_elems[$];
  result_t expected_beats[$];

  logic        in_taken = 1'b0;
  bit          sender_steady = 1'b1;
  bit          receiver_steady = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned fail_count = 0;

  nan_bitmap_sparse_pack_unit #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value_bits(in_value_bits),
    .in_panel_end (in_panel_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_payload  (out_payload),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit is_nan(input logic [VALUE_W-1:0] bits);
    return (bits[62:52] == 11'h7FF) && (bits[51:0] != '0);
  endfunction

  function automatic int unsigned active_length();
    if (row_len == '0) return 1;
    if (row_len > MAX_COLUMNS) return MAX_COLUMNS;
    return 32'(row_len);
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] random_double();
    int unsigned        pick;
    logic               sign;
    logic [VALUE_W-1:0] raw;
    pick = $urandom_range(0, 9);
    sign = 1'($urandom_range(0, 1));
    raw = {$urandom, $urandom};
    if (pick < 3) begin
      if (raw[51:0] == '0) raw[0] = 1'b1;
      return {sign, 11'h7FF, raw[51:0]};
    end
    if (pick == 3) return {sign, 11'h7FF, 52'd0};
    if (pick == 4) return {sign, 11'h000, raw[51:0]};
    return raw;
  endfunction

  // Works out the beats that one accepted element causes and updates the row state.
  task automatic pack_element(input logic [VALUE_W-1:0] bits, input logic pend);
    result_t     beats[RESULTS_MAX];
    int          n;
    int unsigned len;
    logic        row_end;
    logic        word_end;
    n = 0;
    len = active_length();
    row_end = pend || (column + 1 >= len);
    word_end = row_end || (6'(column) == GROUP_LAST_COL);
    if (!is_nan(bits)) begin
      valid_bits[column % BITMAP_W] = 1'b1;
      if (kept_count != KEPT_MAX) kept_count++;
      beats[n] = '{KIND_VALUE, bits, 1'b0};
      n++;
    end
    if (word_end) begin
      beats[n] = '{KIND_BITMAP, valid_bits, 1'b0};
      n++;
      valid_bits = '0;
    end
    if (row_end) begin
      beats[n] = '{KIND_ROW_END, VALUE_W'(kept_count), 1'b0};
      n++;
      column = 0;
    end else begin
      column = column + 1;
    end
    if (pend) begin
      kept_count = '0;
      valid_bits = '0;
      column = 0;
    end
    if (n > 0) beats[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_beats.push_back(beats[i]);
  endtask

  // Monitor: predicts on every accepted element and checks every accepted result beat.
  always @(posedge clk) begin : monitor_proc
    result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual kind %0d payload %h last %b",
                   $time, out_kind, out_payload, out_last);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, out_kind);
            fail_count++;
          end
          if (out_payload !== want.payload) begin
            $display("%0t: payload mismatch, expected %h, actual %h",
                     $time, want.payload, out_payload);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) pack_element(in_value_bits, in_panel_end);
    end
  end

  // Driver: offers queued elements, holding each beat until it is taken.
  always @(negedge clk) begin : driver_proc
    elem_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_elems.size() > 0) begin
      nxt = pending_elems.pop_front();
      in_valid <= 1'b1;
      in_value_bits <= nxt.bits;
      in_panel_end <= nxt.pend;
      send_gap = pick_gap(sender_steady);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap(receiver_steady);
    end
  end

  task automatic queue_elem(input logic [VALUE_W-1:0] bits, input logic pend);
    pending_elems.push_back('{bits, pend});
  endtask

  task automatic queue_random(input int count, input int end_pct);
    @(posedge clk);
    for (int i = 0; i < count; i++)
      queue_elem(random_double(), $urandom_range(0, 99) < end_pct);
  endtask

  // Waits until every beat has arrived, then lets any element without results settle.
  task automatic wait_idle();
    while (pending_elems.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_length(input logic [ROWLEN_W-1:0] len);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    row_len = len;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset row length: zero, NaN edges, infinities and a panel end on a NaN mid-row.
    @(posedge clk);
    queue_elem(64'h0000_0000_0000_0000, 1'b0);
    queue_elem(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_elem(64'h7FF0_0000_0000_0000, 1'b0);
    queue_elem(64'h7FF0_0000_0000_0001, 1'b0);
    queue_elem(64'hFFF0_0000_0000_0000, 1'b0);
    queue_elem(64'h7FF8_0000_0000_0000, 1'b1);
    wait_idle();

    sender_steady = 1'b0;
    receiver_steady = 1'b0;

    // A row length of zero behaves as one column per row.
    write_row_length('0);
    @(posedge clk);
    queue_elem(64'h000F_FFFF_FFFF_FFFF, 1'b0);
    queue_elem(64'hFFF0_0000_0000_0001, 1'b0);
    queue_elem(64'h8000_0000_0000_0000, 1'b0);
    queue_elem(64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
    wait_idle();

    write_row_length(ROWLEN_W'(MAX_COLUMNS));
    @(posedge clk);
    queue_elem(64'h3FF0_0000_0000_0000, 1'b0);
    queue_elem(64'hFFF7_FFFF_FFFF_FFFF, 1'b0);
    queue_elem(64'h0000_0000_0000_0001, 1'b0);
    queue_elem(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
    wait_idle();

    // Leaves the row part-way through, at column 1.
    write_row_length(ROWLEN_W'(2));
    queue_random(5, 0);
    wait_idle();

    // Length changed mid-row; the receiver holds off while elements stream in back to back.
    write_row_length(ROWLEN_W'(65));
    sender_steady = 1'b1;
    hold_token++;
    queue_random(33, 0);
    wait_idle();
    sender_steady = 1'b0;
    queue_random(36, 0);
    wait_idle();

    // The column is now beyond the new length, so the next element closes the row.
    write_row_length(ROWLEN_W'(3));
    queue_random(14, 15);
    wait_idle();

    write_row_length('1);
    queue_random(11, 0);
    queue_elem(random_double(), 1'b1);
    wait_idle();

    write_row_length(ROWLEN_W'(1));
    queue_random(8, 10);
    wait_idle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
